// File: hw/rtl/apd_pkg.sv
package apd_pkg;

   // header geometry
   localparam int HEADER_BYTES   = 24;
   localparam int HDR_STORE_BITS = (HEADER_BYTES - 1) * 8;
   localparam int COUNT_WIDTH    = $clog2(HEADER_BYTES);

   // payload length limits
   localparam int          LEN_WIDTH    = 13;
   localparam int          LENGTH_BOUND = 4096;
   localparam logic [12:0] LEN_LIMIT_RESET = 13'd4096;
   localparam logic [31:0] MAGIC_MASK   = 32'hffff_ffff;

   // result kind codes
   typedef enum logic [1:0] {
      KIND_HEADER    = 2'd0,
      KIND_PAYLOAD   = 2'd1,
      KIND_BAD_MAGIC = 2'd2,
      KIND_OVERSIZE  = 2'd3
   } kind_type;

   // deframer mode
   typedef enum logic [1:0] {
      MODE_HEADER  = 2'b01,
      MODE_PAYLOAD = 2'b10
   } mode_type;

   // one result item
   typedef struct packed {
      kind_type              kind;
      logic [31:0]           command_word;
      logic [31:0]           first_arg;
      logic [31:0]           second_arg;
      logic [LEN_WIDTH-1:0]  payload_length;
      logic [31:0]           check_word;
      logic [7:0]            data_byte;
      logic                  last;
   } result_type;

endpackage

// File: hw/rtl/apd_in_stage.sv
module apd_in_stage
   import apd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       take,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // accept while empty or while the held item moves on
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         byte_in  = req_in_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

// File: hw/rtl/apd_core.sv
module apd_core
   import apd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [LEN_WIDTH-1:0] csr_wr_data,
   input  logic                 advance,
   input  logic [7:0]           in_byte,
   output logic                 res_valid,
   output result_type           res
);

   mode_type                   mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [LEN_WIDTH-1:0]       left_ff, left_in;
   logic [HDR_STORE_BITS-1:0]  hdr_ff, hdr_in;
   logic [LEN_WIDTH-1:0]       max_ff, max_in;

   logic [HDR_STORE_BITS+7:0]  full_hdr;
   logic [31:0]                cmd, arg0, arg1, len, chk, magic;
   logic                       bad_magic, oversize;

   // configuration register
   assign max_in = csr_wr_en ? csr_wr_data : max_ff;

   // header words, little-endian, final byte taken straight from the input
   assign full_hdr = {in_byte, hdr_ff};
   assign cmd      = full_hdr[31:0];
   assign arg0     = full_hdr[63:32];
   assign arg1     = full_hdr[95:64];
   assign len      = full_hdr[127:96];
   assign chk      = full_hdr[159:128];
   assign magic    = full_hdr[191:160];

   assign bad_magic = magic != (cmd ^ MAGIC_MASK);
   assign oversize  = (len > {{(32-LEN_WIDTH){1'b0}}, max_ff}) || (len > 32'(LENGTH_BOUND));

   // per-item update and result decode
   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      hdr_in    = hdr_ff;
      res_valid = 1'b0;
      res       = '0;
      if (advance) begin
         unique case (mode_ff)
            MODE_PAYLOAD: begin
               res_valid     = 1'b1;
               res.kind      = KIND_PAYLOAD;
               res.data_byte = in_byte;
               if (left_ff != '0) begin
                  left_in = left_ff - LEN_WIDTH'(1);
               end
               if (left_ff <= LEN_WIDTH'(1)) begin
                  res.last = 1'b1;
                  mode_in  = MODE_HEADER;
               end
            end
            MODE_HEADER: begin
               hdr_in = {in_byte, hdr_ff[HDR_STORE_BITS-1:8]};
               if (count_ff == COUNT_WIDTH'(HEADER_BYTES - 1)) begin
                  count_in         = '0;
                  res_valid        = 1'b1;
                  res.command_word = cmd;
                  if (bad_magic) begin
                     res.kind = KIND_BAD_MAGIC;
                  end else if (oversize) begin
                     res.kind = KIND_OVERSIZE;
                  end else begin
                     res.kind           = KIND_HEADER;
                     res.first_arg      = arg0;
                     res.second_arg     = arg1;
                     res.payload_length = len[LEN_WIDTH-1:0];
                     res.check_word     = chk;
                     if (len == '0) begin
                        res.last = 1'b1;
                     end else begin
                        left_in = len[LEN_WIDTH-1:0];
                        mode_in = MODE_PAYLOAD;
                     end
                  end
               end else begin
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
            default: begin
               mode_in  = MODE_HEADER;
               count_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_HEADER;
         count_ff <= '0;
         left_ff  <= '0;
         max_ff   <= LEN_LIMIT_RESET;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         max_ff   <= max_in;
      end
      hdr_ff <= hdr_in;
   end

   // header byte count never reaches a full header
   assert property (@(posedge clock) disable iff (reset)
      count_ff < COUNT_WIDTH'(HEADER_BYTES))
      else $error("header count out of range");

   // payload mode always has bytes left and no partial header
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_PAYLOAD |-> (left_ff != '0) && (count_ff == '0))
      else $error("payload mode with bad counters");

   // a good header ends the packet exactly when its length is zero
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_HEADER |-> res.last == (res.payload_length == '0))
      else $error("header last flag wrong");

   // a payload item that is marked last returns to header collection
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_PAYLOAD && res.last |=> mode_ff == MODE_HEADER)
      else $error("mode not back to header after last byte");

endmodule

// File: hw/rtl/apd_out_stage.sv
module apd_out_stage
   import apd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_item,
   output logic       space,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_item
);

   logic       valid_ff, valid_in;
   result_type item_ff, item_in;

   // room for a new item when empty or when the held one is taken now
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = load_item;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// File: hw/rtl/adb_packet_deframer.sv
// path: an accepted byte passes through the input register, then the result
// register; header bytes other than the 24th give no result
// throughput: one byte per cycle while the result register has room
// reset: synchronous, active high; clears the handshake registers and counters,
// restarts header collection and sets the length limit back to 4096
module adb_packet_deframer
   import apd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [LEN_WIDTH-1:0] csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [31:0]          rsp_command_word,
   output logic [31:0]          rsp_first_arg,
   output logic [31:0]          rsp_second_arg,
   output logic [LEN_WIDTH-1:0] rsp_payload_length,
   output logic [31:0]          rsp_check_word,
   output logic [7:0]           rsp_data_byte,
   output logic                 rsp_last
);

   logic       in_valid;
   logic [7:0] in_byte;
   logic       out_space;
   logic       advance;
   logic       res_valid;
   result_type res;
   result_type rsp_item;

   // an item moves on when the result register has room
   assign advance = in_valid && out_space;

   apd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .take        (advance),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   apd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .in_byte     (in_byte),
      .res_valid   (res_valid),
      .res         (res)
   );

   apd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_item (res),
      .space     (out_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // result fields
   assign rsp_kind           = rsp_item.kind;
   assign rsp_command_word   = rsp_item.command_word;
   assign rsp_first_arg      = rsp_item.first_arg;
   assign rsp_second_arg     = rsp_item.second_arg;
   assign rsp_payload_length = rsp_item.payload_length;
   assign rsp_check_word     = rsp_item.check_word;
   assign rsp_data_byte      = rsp_item.data_byte;
   assign rsp_last           = rsp_item.last;

endmodule
